>>> hdl/hhpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhpg_pkg
// Shared widths, register indexes and helpers for the Halton / Hammersley
// point generator.
// ----------------------------------------------------------------------------
package hhpg_pkg;

   localparam int INDEX_BITS = 20;
   localparam int FRAC_BITS  = 24;

   // configuration port
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_MODE         = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_COUNT = CSR_IDX_W'(1);

   localparam logic MODE_HAMMERSLEY = 1'b0;
   localparam logic MODE_HALTON     = 1'b1;

   // base-3 denominator stays below 3 * 2^INDEX_BITS
   localparam int DEN_W = INDEX_BITS + 2;
   localparam int CNT_W = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

   // ceil(2^(INDEX_BITS+1) / 3): exact quotient by 3 for any index
   localparam logic [INDEX_BITS:0] RECIP3 =
      (INDEX_BITS+1)'(((64'd1 << (INDEX_BITS + 1)) + 64'd2) / 64'd3);

   localparam logic [FRAC_BITS:0] COORD_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIGIT  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // base-2 radical inverse, scaled to the fraction width
   function automatic logic [FRAC_BITS-1:0] inverse_base2(
      input logic [INDEX_BITS-1:0] k
   );
      logic [INDEX_BITS-1:0]           rev;
      logic [INDEX_BITS+FRAC_BITS-1:0] wide;
      for (int i = 0; i < INDEX_BITS; i++) begin
         rev[i] = k[INDEX_BITS-1-i];
      end
      wide = {rev, {FRAC_BITS{1'b0}}} >> INDEX_BITS;
      return wide[FRAC_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

>>> hdl/halton_hammersley_point_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// halton_hammersley_point_generator
// Turns a sample index into one 2-D low-discrepancy point, Q1.24 / Q0.24.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_wen / csr_index / csr_wdata write mode (0) and sample_count (1),
//    only while no transaction is in flight; other indexes are ignored.
//  - req_* carries the sample index, rsp_* the x and y coordinates.
//  - one transaction at a time: req_ready is high only when the sequencer
//    is idle; the previous result may still sit in the output register.
//  - Hammersley: load, 24 division steps, hand-over; when k is 0, k >= n or
//    n is 0, the division steps are skipped.
//  - Halton: load, m base-3 digit steps (m <= 13 for 20-bit k), 24 division
//    steps, hand-over; when k is 0, the digit and division steps are skipped.
//  - the division steps run on one shared compare/subtract unit; digit
//    extraction uses one reciprocal multiply by 1/3 per cycle.
//  - a stalled receiver keeps the finished result in the sequencer until
//    the output register frees up.
//  - synchronous reset clears the sequencer, the output valid flag and
//    the registers to mode 0, sample_count 1.
// ----------------------------------------------------------------------------
module halton_hammersley_point_generator
   import hhpg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wen,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [INDEX_BITS-1:0] req_sample_index,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [FRAC_BITS:0]         rsp_x_coord,
   output logic [FRAC_BITS-1:0]       rsp_y_coord
);

   state_type                 state_ff, state_in;
   logic                      cfg_mode_ff, cfg_mode_in;
   logic [INDEX_BITS-1:0]     cfg_count_ff, cfg_count_in;
   logic                      item_mode_ff, item_mode_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   logic [INDEX_BITS-1:0]     work_ff, work_in;
   logic [DEN_W-1:0]          rem_ff, rem_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [FRAC_BITS-1:0]      quo_ff, quo_in;
   logic [FRAC_BITS:0]        x_res_ff, x_res_in;
   logic [FRAC_BITS-1:0]      y_res_ff, y_res_in;
   logic [FRAC_BITS:0]        rsp_x_ff, rsp_x_in;
   logic [FRAC_BITS-1:0]      rsp_y_ff, rsp_y_in;

   logic [INDEX_BITS-1:0]     k_w;
   logic [FRAC_BITS-1:0]      b2_w;
   logic [2*INDEX_BITS:0]     prod_w;
   logic [INDEX_BITS-1:0]     q3_w;
   logic [INDEX_BITS+1:0]     q3x3_w;
   logic [1:0]                digit_w;
   logic [DEN_W+1:0]          rev3_w;
   logic [DEN_W+1:0]          den3_w;
   logic [DEN_W:0]            r2_w;
   logic [DEN_W:0]            diff_w;
   logic                      ge_w;

   // configuration registers
   always_comb begin
      cfg_mode_in  = cfg_mode_ff;
      cfg_count_in = cfg_count_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_MODE:         cfg_mode_in  = csr_wdata[0];
            REG_SAMPLE_COUNT: cfg_count_in = csr_wdata[INDEX_BITS-1:0];
            default: ;
         endcase
      end
   end

   // shared datapath
   assign k_w     = req_sample_index[INDEX_BITS-1:0];
   assign b2_w    = inverse_base2(k_w);
   assign prod_w  = (2*INDEX_BITS+1)'(work_ff) * (2*INDEX_BITS+1)'(RECIP3);
   assign q3_w    = prod_w[2*INDEX_BITS:INDEX_BITS+1];
   assign q3x3_w  = {1'b0, q3_w, 1'b0} + {2'b00, q3_w};
   assign digit_w = work_ff[1:0] - q3x3_w[1:0];
   assign rev3_w  = {1'b0, rem_ff, 1'b0} + {2'b00, rem_ff} + {{DEN_W{1'b0}}, digit_w};
   assign den3_w  = {1'b0, den_ff, 1'b0} + {2'b00, den_ff};
   assign r2_w    = {rem_ff, 1'b0};
   assign ge_w    = r2_w >= {1'b0, den_ff};
   assign diff_w  = r2_w - {1'b0, den_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_mode_in = item_mode_ff;
      count_in     = count_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      x_res_in     = x_res_ff;
      y_res_in     = y_res_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_mode_in = cfg_mode_ff;
               count_in     = '0;
               quo_in       = '0;
               if (cfg_mode_ff == MODE_HAMMERSLEY) begin
                  y_res_in = b2_w;
                  if (k_w == '0) begin
                     x_res_in = '0;
                     state_in = ST_FINISH;
                  end else if (cfg_count_ff == '0 || k_w >= cfg_count_ff) begin
                     x_res_in = COORD_ONE;
                     state_in = ST_FINISH;
                  end else begin
                     rem_in   = DEN_W'(k_w);
                     den_in   = DEN_W'(cfg_count_ff);
                     state_in = ST_DIVIDE;
                  end
               end else begin
                  x_res_in = {1'b0, b2_w};
                  if (k_w == '0) begin
                     y_res_in = '0;
                     state_in = ST_FINISH;
                  end else begin
                     work_in  = k_w;
                     rem_in   = '0;
                     den_in   = DEN_W'(1);
                     state_in = ST_DIGIT;
                  end
               end
            end
         end
         ST_DIGIT: begin
            // one base-3 digit per cycle, least significant first
            work_in = q3_w;
            rem_in  = rev3_w[DEN_W-1:0];
            den_in  = den3_w[DEN_W-1:0];
            if (q3_w == '0) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in   = ge_w ? diff_w[DEN_W-1:0] : r2_w[DEN_W-1:0];
            quo_in   = {quo_ff[FRAC_BITS-2:0], ge_w};
            count_in = count_ff + CNT_W'(1);
            if (count_ff == CNT_W'(FRAC_BITS - 1)) begin
               if (item_mode_ff == MODE_HAMMERSLEY) begin
                  x_res_in = {1'b0, quo_in};
               end else begin
                  y_res_in = quo_in;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_res_ff;
               rsp_y_in     = y_res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_mode_ff  <= MODE_HAMMERSLEY;
         cfg_count_ff <= INDEX_BITS'(1);
         item_mode_ff <= MODE_HAMMERSLEY;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cfg_mode_ff  <= cfg_mode_in;
         cfg_count_ff <= cfg_count_in;
         item_mode_ff <= item_mode_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
      x_res_ff <= x_res_in;
      y_res_ff <= y_res_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_x_coord = rsp_x_ff;
   assign rsp_y_coord = rsp_y_ff;

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("sequencer idle right after a transaction was taken");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT || state_ff == ST_DIVIDE) |-> (rem_ff < den_ff))
      else $error("partial remainder not below divisor");

   a_x_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_x_ff <= COORD_ONE))
      else $error("x coordinate above one");

endmodule
`default_nettype wire
